>>> hdl/svel_pkg.sv
`default_nettype none

package svel_pkg;

    localparam int POLE_COUNT_DEF = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [24:0] ONE_Q24       = 25'h100_0000;
    localparam logic [23:0] LEVEL_MAX     = 24'hFF_FFFF;
    localparam logic [15:0] GAIN_Q16      = 16'd58982;   // 0.9
    localparam logic [31:0] MIDDLE_C_STEP = 32'd25480551;
    localparam logic [16:0] MIX_ONE       = 17'h1_0000;

    localparam logic [23:0] ATTACK_RST  = 24'd95106;
    localparam logic [23:0] RELEASE_RST = 24'd16767706;
    localparam logic [15:0] COEFF_RST   = 16'd2742;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK      = 3'd0,
        CFG_RELEASE     = 3'd1,
        CFG_COEFF       = 3'd2,
        CFG_NOISE_MIX   = 3'd3,
        CFG_SPREAD_MIX  = 3'd4,
        CFG_VELOCITY_ON = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [23:0] attack_step;
        logic [23:0] release_factor;
        logic [15:0] filter_coeff;
        logic [16:0] noise_mix;     // already limited to one
        logic [16:0] spread_mix;    // already limited to one
        logic        velocity_on;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         operation;
        logic [6:0]         velocity;
        logic [31:0]        phase_step;
        logic signed [15:0] noise_main;
        logic signed [15:0] noise_side;
    } t_item;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } t_result;

    // velocity to envelope target, floor(vel * 2^24 / 127)
    localparam int VEL_LEVELS = 128;
    localparam int VEL_FULL   = 127;

    typedef logic [24:0] t_target_tab [VEL_LEVELS];

    function automatic t_target_tab f_target_tab();
        t_target_tab tab;
        for (int i = 0; i < VEL_LEVELS; i++) begin
            tab[i] = 25'((64'(i) << 24) / VEL_FULL);
        end
        return tab;
    endfunction

    localparam t_target_tab TARGET_TAB = f_target_tab();

endpackage

`default_nettype wire

>>> hdl/svel_in_if.sv
`default_nettype none

interface svel_in_if ();
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [6:0]         velocity;
    logic [31:0]        phase_step;
    logic signed [15:0] noise_main;
    logic signed [15:0] noise_side;

    modport source (
        output valid, operation, velocity, phase_step, noise_main, noise_side,
        input  ready
    );
    modport sink (
        input  valid, operation, velocity, phase_step, noise_main, noise_side,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/svel_out_if.sv
`default_nettype none

interface svel_out_if ();
    logic               valid;
    logic               ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;

    modport source (
        output valid, left_sample, right_sample,
        input  ready
    );
    modport sink (
        input  valid, left_sample, right_sample,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/svel_cfg.sv
`default_nettype none

module svel_cfg import svel_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    logic [23:0] r_attack;
    logic [23:0] r_release;
    logic [15:0] r_coeff;
    logic [16:0] r_noise_mix;
    logic [16:0] r_spread_mix;
    logic        r_velocity_on;

    function automatic logic [16:0] f_limit_one(input logic [16:0] v);
        if (v[16] && (v[15:0] != 16'd0)) begin
            return MIX_ONE;
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack      <= ATTACK_RST;
            r_release     <= RELEASE_RST;
            r_coeff       <= COEFF_RST;
            r_noise_mix   <= 17'd0;
            r_spread_mix  <= 17'd0;
            r_velocity_on <= 1'b1;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_ATTACK:      r_attack      <= i_data;
                CFG_RELEASE:     r_release     <= i_data;
                CFG_COEFF:       r_coeff       <= i_data[15:0];
                CFG_NOISE_MIX:   r_noise_mix   <= i_data[16:0];
                CFG_SPREAD_MIX:  r_spread_mix  <= i_data[16:0];
                CFG_VELOCITY_ON: r_velocity_on <= i_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.attack_step    = r_attack;
        o_cfg.release_factor = r_release;
        o_cfg.filter_coeff   = r_coeff;
        o_cfg.noise_mix      = f_limit_one(r_noise_mix);
        o_cfg.spread_mix     = f_limit_one(r_spread_mix);
        o_cfg.velocity_on    = r_velocity_on;
    end

endmodule

`default_nettype wire

>>> hdl/svel_mul.sv
`default_nettype none

module svel_mul import svel_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> hdl/svel_engine.sv
`default_nettype none

module svel_engine import svel_pkg::*; #(
    parameter int POLE_COUNT = POLE_COUNT_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_item   i_item,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    localparam int IDX_W = (POLE_COUNT > 1) ? $clog2(POLE_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_POLE = IDX_W'(POLE_COUNT - 1);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_ENV      = 11'b000_0000_0010,
        S_MIX0     = 11'b000_0000_0100,
        S_MIX1     = 11'b000_0000_1000,
        S_GAIN     = 11'b000_0001_0000,
        S_POLE_ISS = 11'b000_0010_0000,
        S_POLE_UPD = 11'b000_0100_0000,
        S_RIGHT    = 11'b000_1000_0000,
        S_LEFT     = 11'b001_0000_0000,
        S_RMUL     = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // voice state
    logic [31:0]        r_phase;
    logic [31:0]        r_step;
    logic [23:0]        r_level;
    logic [24:0]        r_target;
    logic               r_gate;
    logic signed [23:0] r_main [POLE_COUNT];
    logic signed [23:0] r_sidep [POLE_COUNT];

    // per-tick working registers
    logic signed [15:0] r_nmain;
    logic signed [15:0] r_nside;
    logic signed [40:0] r_acc;
    logic signed [23:0] r_x;
    logic signed [23:0] r_filt;
    logic signed [23:0] r_right;
    logic [23:0]        r_gain;
    logic signed [15:0] r_left;
    logic [IDX_W-1:0]   r_pole;
    logic               r_side;

    logic signed [MUL_W-1:0]  w_a, w_b;
    logic signed [PROD_W-1:0] w_prod;
    logic                     w_mul_en;

    logic signed [23:0]       w_saw;
    logic signed [23:0]       w_nmain;
    logic signed [23:0]       w_nside;
    logic [16:0]              w_mix_inv;
    logic signed [PROD_W-1:0] w_mix_sum;
    logic signed [23:0]       w_cur;
    logic signed [24:0]       w_diff;
    logic signed [25:0]       w_pole_new;
    logic signed [24:0]       w_spread_diff;
    logic signed [25:0]       w_right_sum;
    logic signed [19:0]       w_out_hi;
    logic [25:0]              w_lv_up;
    logic [25:0]              w_lv_clip;
    logic [23:0]              w_lv_new;
    logic                     w_accept;

    function automatic logic signed [15:0] f_sat16(input logic signed [19:0] v);
        if (v > 20'sd32767) begin
            return 16'sh7FFF;
        end
        if (v < -20'sd32768) begin
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

    svel_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    // product must hold while the finished result waits
    assign w_mul_en = (r_state != S_IDLE) && (r_state != S_DONE);

    assign w_saw         = $signed({~r_phase[31], r_phase[30:8]});
    assign w_nmain       = $signed({r_nmain, 8'h00});
    assign w_nside       = $signed({r_nside, 8'h00});
    assign w_mix_inv     = MIX_ONE - i_cfg.noise_mix;
    assign w_mix_sum     = r_acc + w_prod;
    assign w_cur         = r_side ? r_sidep[r_pole] : r_main[r_pole];
    assign w_diff        = r_x - w_cur;
    assign w_pole_new    = w_cur + $signed(w_prod[41:16]);
    assign w_spread_diff = r_x - r_filt;
    assign w_right_sum   = r_filt + $signed(w_prod[41:16]);
    assign w_out_hi      = $signed(w_prod[51:32]);

    // attack ramps toward target and clips there; release is a plain decay
    assign w_lv_up   = 26'(r_level) + 26'(w_prod[48:24]);
    assign w_lv_clip = (w_lv_up > 26'(r_target)) ? 26'(r_target) : w_lv_up;
    assign w_lv_new  = r_gate ? ((w_lv_clip > 26'(LEVEL_MAX)) ? LEVEL_MAX : w_lv_clip[23:0])
                              : w_prod[47:24];

    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (r_state)
            S_ENV: begin
                if (r_gate) begin
                    w_a = $signed(MUL_W'(r_target));
                    w_b = $signed(MUL_W'(i_cfg.attack_step));
                end else begin
                    w_a = $signed(MUL_W'(r_level));
                    w_b = $signed(MUL_W'(i_cfg.release_factor));
                end
            end
            S_MIX0: begin
                w_a = $signed(MUL_W'(w_mix_inv));
                w_b = MUL_W'(w_saw);
            end
            S_MIX1: begin
                w_a = $signed(MUL_W'(i_cfg.noise_mix));
                w_b = MUL_W'(w_nmain);
            end
            S_GAIN: begin
                w_a = $signed(MUL_W'(r_level));
                w_b = $signed(MUL_W'(GAIN_Q16));
            end
            S_POLE_ISS: begin
                w_a = $signed(MUL_W'(i_cfg.filter_coeff));
                w_b = MUL_W'(w_diff);
            end
            S_RIGHT: begin
                w_a = $signed(MUL_W'(i_cfg.spread_mix));
                w_b = MUL_W'(w_spread_diff);
            end
            S_LEFT: begin
                w_a = MUL_W'(r_filt);
                w_b = $signed(MUL_W'(r_gain));
            end
            S_RMUL: begin
                w_a = MUL_W'(r_right);
                w_b = $signed(MUL_W'(r_gain));
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_item.operation == OP_TICK)) begin
                    n_state = S_ENV;
                end
            end
            S_ENV:      n_state = S_MIX0;
            S_MIX0:     n_state = S_MIX1;
            S_MIX1:     n_state = S_GAIN;
            S_GAIN:     n_state = S_POLE_ISS;
            S_POLE_ISS: n_state = S_POLE_UPD;
            S_POLE_UPD: begin
                if (r_pole != LAST_POLE) begin
                    n_state = S_POLE_ISS;
                end else if (!r_side && (i_cfg.spread_mix != 17'd0)) begin
                    n_state = S_POLE_ISS;
                end else begin
                    n_state = S_RIGHT;
                end
            end
            S_RIGHT:    n_state = S_LEFT;
            S_LEFT:     n_state = S_RMUL;
            S_RMUL:     n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= 32'd0;
            r_step   <= MIDDLE_C_STEP;
            r_level  <= 24'd0;
            r_target <= ONE_Q24;
            r_gate   <= 1'b0;
            r_pole   <= '0;
            r_side   <= 1'b0;
            for (int i = 0; i < POLE_COUNT; i++) begin
                r_main[i]  <= '0;
                r_sidep[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                case (i_item.operation)
                    OP_TICK: begin
                        r_phase <= r_phase + r_step;
                        r_pole  <= '0;
                        r_side  <= 1'b0;
                    end
                    OP_NOTE_ON: begin
                        // zero velocity behaves as note-off
                        if (i_item.velocity == 7'd0) begin
                            r_gate <= 1'b0;
                        end else begin
                            r_gate   <= 1'b1;
                            r_target <= i_cfg.velocity_on ? TARGET_TAB[i_item.velocity]
                                                          : ONE_Q24;
                            r_step   <= i_item.phase_step;
                        end
                    end
                    OP_NOTE_OFF: r_gate <= 1'b0;
                    default: ;
                endcase
            end
            if (r_state == S_MIX0) begin
                r_level <= w_lv_new;
            end
            if (r_state == S_POLE_UPD) begin
                if (r_side) begin
                    r_sidep[r_pole] <= w_pole_new[23:0];
                end else begin
                    r_main[r_pole] <= w_pole_new[23:0];
                end
                if (r_pole != LAST_POLE) begin
                    r_pole <= r_pole + 1'b1;
                end else if (!r_side) begin
                    r_pole <= '0;
                    r_side <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_nmain <= i_item.noise_main;
            r_nside <= i_item.noise_side;
        end
        unique case (r_state)
            S_MIX1:     r_acc <= w_prod[40:0];
            S_GAIN:     r_x <= w_mix_sum[39:16];
            S_POLE_ISS: begin
                if ((r_pole == '0) && !r_side) begin
                    r_gain <= w_prod[39:16];
                end
            end
            S_POLE_UPD: begin
                if (!r_side && (r_pole == LAST_POLE)) begin
                    r_filt <= w_pole_new[23:0];
                end
                // side chain starts from its own noise
                if (!r_side && (r_pole == LAST_POLE) && (i_cfg.spread_mix != 17'd0)) begin
                    r_x <= w_nside;
                end else begin
                    r_x <= w_pole_new[23:0];
                end
            end
            S_LEFT:     r_right <= w_right_sum[23:0];
            S_RMUL:     r_left <= f_sat16(w_out_hi);
            default: ;
        endcase
    end

    assign o_res_valid        = (r_state == S_DONE);
    assign o_res.left_sample  = r_left;
    assign o_res.right_sample = f_sat16(w_out_hi);

    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_item.operation == OP_TICK)) |=> (r_state == S_ENV))
        else $error("tick accepted but sequence did not start");

    a_pole_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_POLE_ISS) || (r_state == S_POLE_UPD)) |-> (r_pole <= LAST_POLE))
        else $error("pole index out of range");

    a_side_only_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_POLE_ISS) && r_side) |-> (i_cfg.spread_mix != 17'd0))
        else $error("side poles running with zero spread");

    a_done_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> ($past(r_state) == S_RMUL || $past(r_state) == S_DONE))
        else $error("result state entered out of sequence");

endmodule

`default_nettype wire

>>> hdl/saw_voice_with_envelope_and_lowpass_top.sv
// Monophonic sawtooth/noise voice with envelope and a multi-pole lowpass.
// Input channel i_item (valid/ready): operation 0 is a sample tick carrying
// noise_main/noise_side, 1 is note-on (velocity, phase_step), 2 is note-off.
// Note items are accepted while idle and give no result. A tick gives one
// stereo sample on o_res (valid/ready).
// A tick is worked through one shared 26x26 multiplier under a sequencer
// that steps through the envelope, mix and gain, the main filter poles,
// and also the side noise poles when spread_mix is non-zero. The next item
// is taken in the cycle after the result leaves the sequencer.
// Note items sustain one per cycle while the sequencer is idle.
// The result sits in an output register, so a stalled receiver holds one
// sample while the next item is already accepted and processed; the
// sequencer waits only if a second result is ready before the first is taken.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data, written while idle.
// Synchronous reset restores default settings, zero phase, envelope and
// filter state, middle-C step, and empties the output register.
`default_nettype none

module saw_voice_with_envelope_and_lowpass_top import svel_pkg::*; #(
    parameter int POLE_COUNT = POLE_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    svel_in_if.sink               i_item,
    svel_out_if.source            o_res
);

    t_cfg    w_cfg;
    t_item   w_item;
    t_result w_res;
    logic    w_res_valid;
    logic    w_res_ready;
    logic    w_ready;

    logic    r_out_valid;
    t_result r_out;

    svel_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    always_comb begin
        w_item.operation  = i_item.operation;
        w_item.velocity   = i_item.velocity;
        w_item.phase_step = i_item.phase_step;
        w_item.noise_main = i_item.noise_main;
        w_item.noise_side = i_item.noise_side;
    end

    svel_engine #(
        .POLE_COUNT (POLE_COUNT)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (i_item.valid),
        .o_ready     (w_ready),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    assign i_item.ready = w_ready;

    // output register frees the sequencer from a stalled receiver
    assign w_res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.left_sample  = r_out.left_sample;
    assign o_res.right_sample = r_out.right_sample;

endmodule

`default_nettype wire
